FILE: design/acpu_pkg.sv
// Shared types and constants for the accumulator machine execute block.
// Holds the opcode map, the controller states and the controller/datapath links.
// No dependencies.
package acpu_pkg;

    // Instruction opcodes; any value above OP_HALT is a no-op.
    typedef enum logic [7:0] {
        OP_LOAD    = 8'd0,
        OP_LOADI   = 8'd1,
        OP_STORE   = 8'd2,
        OP_ADD     = 8'd3,
        OP_SUB     = 8'd4,
        OP_MUL     = 8'd5,
        OP_DIV     = 8'd6,
        OP_INC     = 8'd7,
        OP_DEC     = 8'd8,
        OP_AND     = 8'd9,
        OP_OR      = 8'd10,
        OP_NOT     = 8'd11,
        OP_JMP     = 8'd12,
        OP_JZ      = 8'd13,
        OP_JNZ     = 8'd14,
        OP_JPOS    = 8'd15,
        OP_JNEG    = 8'd16,
        OP_JGEZ    = 8'd17,
        OP_JLEZ    = 8'd18,
        OP_HALT    = 8'd19
    } opcode_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_needed;
        logic div_last;
        logic out_free;
    } dp_status_t;

    localparam int PC_WIDTH    = 9;
    localparam int OUT_ACC_W   = 32;
    localparam int BYTE_W      = 8;

endpackage

FILE: design/acpu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module acpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/acpu_ctrl.sv
// Controller state machine for the accumulator machine execute block.
// Depends on acpu_pkg for states, commands and status.
module acpu_ctrl
    import acpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.div_needed ? ST_DIV : ST_OUT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted item is always executed in the following cycle.
    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed next cycle");

    // Execution leaves for the divider only when a divide was flagged.
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !status.div_needed) |=> (state_reg == ST_OUT))
        else $error("entered divide without a divide instruction");

    // The result is loaded only when the output slot is free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded into a full output slot");

endmodule

FILE: design/acpu_dpath.sv
// Datapath for the accumulator machine: architectural state, data memory,
// serial divider and output register. Depends on acpu_pkg and acpu_ram.
module acpu_dpath
    import acpu_pkg::*;
#(
    parameter int DATA_DEPTH = 256,
    parameter int PROG_DEPTH = 256,
    parameter int ACC_WIDTH  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [15:0]          s_tdata,
    input  logic                 cfg_valid,
    input  logic [PC_WIDTH-1:0]  cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [47:0]          m_tdata
);

    localparam int DATA_AW = $clog2(DATA_DEPTH);
    localparam int CNT_W   = $clog2(ACC_WIDTH);

    // Data address is the operand reduced modulo the memory depth.
    function automatic logic [DATA_AW-1:0] data_addr(input logic [BYTE_W-1:0] op);
        logic [11:0] r;
        r = {4'b0000, op};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= 12'(DATA_DEPTH << k))
            begin
                r = r - 12'(DATA_DEPTH << k);
            end
        end
        return r[DATA_AW-1:0];
    endfunction

    // Architectural state.
    logic [ACC_WIDTH-1:0]  acc_reg, acc_next;
    logic [PC_WIDTH-1:0]   pc_reg, pc_next;
    logic                  halt_reg, halt_next;
    logic                  dz_reg, dz_next;
    logic [PC_WIDTH-1:0]   prog_len_reg;
    logic [DATA_DEPTH-1:0] mem_valid_reg;

    // Current instruction.
    logic [BYTE_W-1:0]     func_reg;
    logic [BYTE_W-1:0]     operand_reg;
    logic [DATA_AW-1:0]    addr_reg;
    logic                  rd_valid_reg;

    // Divider state.
    logic [BYTE_W-1:0]     div_rem_reg;
    logic [ACC_WIDTH-1:0]  div_q_reg;
    logic [CNT_W-1:0]      div_cnt_reg;
    logic                  div_neg_reg;

    // Output register.
    logic                  m_tvalid_reg;
    logic [47:0]           m_tdata_reg;

    logic [DATA_AW-1:0]    rd_addr;
    logic [BYTE_W-1:0]     ram_rdata;
    logic [BYTE_W-1:0]     mem_byte;
    logic [ACC_WIDTH-1:0]  mem_ext;
    logic [ACC_WIDTH-1:0]  prod;
    logic                  run_ok;
    logic                  acc_zero;
    logic                  acc_neg;
    logic                  take;
    logic [PC_WIDTH-1:0]   target;
    logic                  store_en;
    logic                  div_needed;
    logic [ACC_WIDTH-1:0]  acc_mag;
    logic [BYTE_W:0]       div_trial;
    logic                  div_ge;
    logic [BYTE_W-1:0]     rem_step;
    logic [ACC_WIDTH-1:0]  q_step;
    logic                  div_last;
    logic                  out_free;
    logic [PC_WIDTH-1:0]   cfg_sat;

    // Data memory; entries never stored read as zero.
    assign rd_addr = data_addr(s_tdata[15:8]);

    acpu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (store_en),
        .waddr (addr_reg),
        .wdata (acc_reg[BYTE_W-1:0]),
        .re    (cmd.accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign mem_byte = rd_valid_reg ? ram_rdata : '0;
    assign mem_ext  = ACC_WIDTH'(mem_byte);
    assign prod     = acc_reg * mem_ext;

    assign run_ok   = !halt_reg && (pc_reg < prog_len_reg);
    assign acc_zero = (acc_reg == '0);
    assign acc_neg  = acc_reg[ACC_WIDTH-1];
    assign acc_mag  = acc_neg ? (~acc_reg + 1'b1) : acc_reg;
    assign target   = PC_WIDTH'(operand_reg[BYTE_W-1:1]);

    // Instruction execution.
    always_comb
    begin
        acc_next   = acc_reg;
        pc_next    = pc_reg + 1'b1;
        halt_next  = halt_reg;
        dz_next    = 1'b0;
        take       = 1'b0;
        store_en   = 1'b0;
        div_needed = 1'b0;
        if (!run_ok)
        begin
            pc_next   = pc_reg;
            halt_next = 1'b1;
        end
        else
        begin
            case (func_reg)
                OP_LOAD:  acc_next = mem_ext;
                OP_LOADI: acc_next = ACC_WIDTH'(operand_reg);
                OP_STORE: store_en = cmd.exec;
                OP_ADD:   acc_next = acc_reg + mem_ext;
                OP_SUB:   acc_next = acc_reg - mem_ext;
                OP_MUL:   acc_next = prod;
                OP_DIV:
                begin
                    if (mem_byte == '0)
                    begin
                        dz_next = 1'b1;
                    end
                    else
                    begin
                        div_needed = 1'b1;
                    end
                end
                OP_INC:   acc_next = acc_reg + 1'b1;
                OP_DEC:   acc_next = acc_reg - 1'b1;
                OP_AND:   acc_next = acc_reg & mem_ext;
                OP_OR:    acc_next = acc_reg | mem_ext;
                OP_NOT:   acc_next = ~acc_reg;
                OP_JMP:   take = 1'b1;
                OP_JZ:    take = acc_zero;
                OP_JNZ:   take = !acc_zero;
                OP_JPOS:  take = !acc_neg && !acc_zero;
                OP_JNEG:  take = acc_neg;
                OP_JGEZ:  take = !acc_neg;
                OP_JLEZ:  take = acc_neg || acc_zero;
                OP_HALT:
                begin
                    halt_next = 1'b1;
                    pc_next   = prog_len_reg;
                end
                default:  acc_next = acc_reg;
            endcase
            if (take)
            begin
                pc_next = target;
            end
            // Running past the program end halts at the program length.
            if (pc_next >= prog_len_reg)
            begin
                pc_next   = prog_len_reg;
                halt_next = 1'b1;
            end
        end
    end

    // One restoring divide step per cycle on the accumulator magnitude.
    assign div_trial = {div_rem_reg, div_q_reg[ACC_WIDTH-1]};
    assign div_ge    = (div_trial >= {1'b0, mem_byte});
    assign rem_step  = div_ge ? BYTE_W'(div_trial - {1'b0, mem_byte})
                              : div_trial[BYTE_W-1:0];
    assign q_step    = {div_q_reg[ACC_WIDTH-2:0], div_ge};
    assign div_last  = (div_cnt_reg == CNT_W'(ACC_WIDTH - 1));

    assign out_free  = !m_tvalid_reg || m_tready;

    assign status.div_needed = div_needed;
    assign status.div_last   = div_last;
    assign status.out_free   = out_free;

    // Saturate the program length to the program store depth.
    assign cfg_sat = (cfg_data > PC_WIDTH'(PROG_DEPTH)) ? PC_WIDTH'(PROG_DEPTH) : cfg_data;

    // Control state: architectural registers, valid bits and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            dz_reg        <= 1'b0;
            prog_len_reg  <= PC_WIDTH'(PROG_DEPTH);
            mem_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                prog_len_reg <= cfg_sat;
            end
            if (cmd.exec)
            begin
                acc_reg     <= acc_next;
                pc_reg      <= pc_next;
                halt_reg    <= halt_next;
                dz_reg      <= dz_next;
                div_cnt_reg <= '0;
            end
            if (store_en)
            begin
                mem_valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    acc_reg <= div_neg_reg ? (~q_step + 1'b1) : q_step;
                end
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg     <= s_tdata[7:0];
            operand_reg  <= s_tdata[15:8];
            addr_reg     <= rd_addr;
            rd_valid_reg <= mem_valid_reg[rd_addr];
        end
        if (cmd.exec)
        begin
            div_rem_reg <= '0;
            div_q_reg   <= acc_mag;
            div_neg_reg <= acc_neg;
        end
        if (cmd.div_step)
        begin
            div_rem_reg <= rem_step;
            div_q_reg   <= q_step;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {5'b00000, dz_reg,
                            (halt_reg || (pc_reg >= prog_len_reg)),
                            pc_reg, OUT_ACC_W'(signed'(acc_reg))};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A halted machine leaves accumulator and counter untouched.
    a_halted_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && !run_ok) |=> ($stable(acc_reg) && $stable(pc_reg) && halt_reg))
        else $error("halted machine changed state");

    // The program length never exceeds the program store depth.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prog_len_reg <= PC_WIDTH'(PROG_DEPTH))
        else $error("program length above program depth");

    // A divide by zero never starts the divider.
    a_dz_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && dz_next) |-> !div_needed)
        else $error("divider started on a zero divisor");

endmodule

FILE: design/accumulator_cpu_execute_top.sv
// An accepted item passes through accept, execute and output load; a divide with a
// nonzero divisor adds the bit-serial divider steps before the output load. A new
// item is accepted only after the result is loaded, which waits for a free output
// slot. The divider produces one quotient bit per cycle.
// Reset clears accumulator, counter, halt flag and output valid, sets the program
// length to PROG_DEPTH, and clears the data memory's valid bits so it reads as zero.
// Top level of the accumulator machine execute block.
// Depends on acpu_pkg, acpu_ctrl, acpu_dpath and acpu_ram.
module accumulator_cpu_execute_top
    import acpu_pkg::*;
#(
    parameter int DATA_DEPTH = 256,
    parameter int PROG_DEPTH = 256,
    parameter int ACC_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] func, [15:8] operand
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] accumulator, [40:32] next_pc,
                                   // [41] halted, [42] div_zero, [47:43] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // program_length
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration is taken in any cycle.
    assign cfg_ready = 1'b1;

    // Controller.
    acpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    acpu_dpath #(
        .DATA_DEPTH (DATA_DEPTH),
        .PROG_DEPTH (PROG_DEPTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
